### design/bcrs_pkg.sv
`default_nettype none

package bcrs_pkg;

  localparam int ADC_WIDTH = 24;

  localparam int PHASE_W = 4;
  localparam int OSR_W = 3;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 3;

  // Sequencer phases.
  localparam logic [PHASE_W-1:0] PH_CONV_P = 4'd0;
  localparam logic [PHASE_W-1:0] PH_WAIT_P = 4'd1;
  localparam logic [PHASE_W-1:0] PH_READ_P = 4'd2;
  localparam logic [PHASE_W-1:0] PH_CONV_T = 4'd3;
  localparam logic [PHASE_W-1:0] PH_WAIT_T = 4'd4;
  localparam logic [PHASE_W-1:0] PH_READ_T = 4'd5;
  localparam logic [PHASE_W-1:0] PH_FINISH = 4'd6;
  localparam logic [PHASE_W-1:0] PH_DONE   = 4'd7;
  localparam logic [PHASE_W-1:0] PH_FAIL   = 4'd8;

  // Events.
  localparam logic [1:0] EV_START = 2'd0;
  localparam logic [1:0] EV_TX    = 2'd1;
  localparam logic [1:0] EV_DELAY = 2'd2;
  localparam logic [1:0] EV_XFER  = 2'd3;

  // Actions.
  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_SEND  = 2'd1;
  localparam logic [1:0] ACT_DELAY = 2'd2;
  localparam logic [1:0] ACT_READ  = 2'd3;

  // Status codes.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_BUSY = 2'd1;
  localparam logic [1:0] ST_FAIL = 2'd2;
  localparam logic [1:0] ST_LINK = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_PRESSURE_OSR    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TEMPERATURE_OSR = 2'd1;

  localparam logic [OSR_W-1:0] OSR_MAX = 3'd4;

  localparam logic [7:0] CMD_PRESSURE_BASE    = 8'h40;
  localparam logic [7:0] CMD_TEMPERATURE_BASE = 8'h50;
  localparam logic [7:0] CMD_ADC_READ         = 8'h00;

  typedef struct packed {
    logic [1:0]  req_type;
    logic        action_accepted;
    logic [23:0] adc_word;
  } bcrs_in_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  cmd_byte;
    logic [13:0] delay_us;
    logic [1:0]  status;
    logic        data_ready;
    logic [3:0]  phase;
    logic [23:0] raw_pressure;
    logic [23:0] raw_temperature;
  } bcrs_out_t;

  function automatic logic [OSR_W-1:0] osr_sat(input logic [OSR_W-1:0] osr);
    return (osr > OSR_MAX) ? OSR_MAX : osr;
  endfunction

  // Conversion wait for a saturated oversampling code.
  function automatic logic [13:0] conv_delay(input logic [OSR_W-1:0] osr);
    logic [13:0] d;
    unique case (osr_sat(osr))
      3'd0:    d = 14'd600;
      3'd1:    d = 14'd1170;
      3'd2:    d = 14'd2280;
      3'd3:    d = 14'd4540;
      default: d = 14'd9040;
    endcase
    return d;
  endfunction

  function automatic logic [7:0] conv_cmd(input logic [7:0] base,
                                          input logic [OSR_W-1:0] osr);
    return base + {4'd0, osr_sat(osr), 1'b0};
  endfunction

endpackage

`default_nettype wire

### design/baro_conversion_read_sequencer.sv
`default_nettype none

// Barometer conversion sequencer: each accepted event word is answered by exactly one result
// word in the next cycle, and a new event may be accepted on every cycle provided the result
// register is free or is being taken in the same cycle; the phase register and the two raw ADC
// stores update at that accept edge, so consecutive events see each other's effects with no gap.
// After reset the phase is fail, so the first useful event is a start read. Configuration writes
// are always taken at once; indexes beyond the two oversampling registers are ignored.
module baro_conversion_read_sequencer
  import bcrs_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire bcrs_in_t               in_data,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output bcrs_out_t                   out_data,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [PHASE_W-1:0]   seq_phase;
  logic [PHASE_W-1:0]   seq_phase_next;
  logic [ADC_WIDTH-1:0] pressure_word;
  logic [ADC_WIDTH-1:0] pressure_word_next;
  logic [ADC_WIDTH-1:0] temperature_word;
  logic [ADC_WIDTH-1:0] temperature_word_next;
  logic [OSR_W-1:0]     pressure_osr;
  logic [OSR_W-1:0]     temperature_osr;
  bcrs_out_t            result_next;
  logic                 in_fire;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pressure_osr    <= '0;
      temperature_osr <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == REG_PRESSURE_OSR) begin
        pressure_osr <= cfg_data;
      end else if (cfg_index == REG_TEMPERATURE_OSR) begin
        temperature_osr <= cfg_data;
      end
    end
  end

  always_comb begin
    logic [PHASE_W-1:0]   ph;
    logic [PHASE_W-1:0]   target;
    logic [1:0]           fail_code;
    logic [ADC_WIDTH-1:0] word;

    ph        = (seq_phase > PH_FAIL) ? PH_FAIL : seq_phase;
    target    = PH_FAIL;
    fail_code = ST_OK;
    word      = in_data.adc_word[ADC_WIDTH-1:0];

    result_next           = '0;
    pressure_word_next    = pressure_word;
    temperature_word_next = temperature_word;

    priority if (in_data.req_type == EV_START) begin
      if (ph == PH_DONE || ph == PH_FAIL) begin
        result_next.action   = ACT_SEND;
        result_next.cmd_byte = conv_cmd(CMD_PRESSURE_BASE, pressure_osr);
        target               = PH_WAIT_P;
        fail_code            = ST_LINK;
      end else begin
        result_next.status = ST_BUSY;
      end
    end else if (in_data.req_type == EV_TX && (ph == PH_WAIT_P || ph == PH_WAIT_T)) begin
      result_next.action   = ACT_DELAY;
      result_next.delay_us = conv_delay((ph == PH_WAIT_P) ? pressure_osr : temperature_osr);
      target               = ph + 4'd1;
      fail_code            = ST_FAIL;
    end else if (in_data.req_type == EV_DELAY && (ph == PH_READ_P || ph == PH_READ_T)) begin
      result_next.action   = ACT_READ;
      result_next.cmd_byte = CMD_ADC_READ;
      target               = ph + 4'd1;
      fail_code            = ST_LINK;
    end else if (in_data.req_type == EV_XFER && ph == PH_CONV_T) begin
      // The pressure word is kept even when the temperature command is refused.
      pressure_word_next   = word;
      result_next.action   = ACT_SEND;
      result_next.cmd_byte = conv_cmd(CMD_TEMPERATURE_BASE, temperature_osr);
      target               = PH_WAIT_T;
      fail_code            = ST_LINK;
    end else if (in_data.req_type == EV_XFER && ph == PH_FINISH) begin
      temperature_word_next = word;
      ph                    = PH_DONE;
    end else if (ph == PH_FAIL) begin
      result_next.status = ST_FAIL;
    end else begin
      // Events that do not match the phase are ignored.
      ph = ph;
    end

    if (result_next.action != ACT_NONE) begin
      if (in_data.action_accepted) begin
        ph = target;
      end else begin
        ph                 = PH_FAIL;
        result_next.status = fail_code;
      end
    end

    seq_phase_next              = ph;
    result_next.phase           = ph;
    result_next.data_ready      = (ph == PH_DONE);
    result_next.raw_pressure    = 24'(pressure_word_next);
    result_next.raw_temperature = 24'(temperature_word_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_phase        <= PH_FAIL;
      pressure_word    <= '0;
      temperature_word <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (in_fire) begin
        seq_phase        <= seq_phase_next;
        pressure_word    <= pressure_word_next;
        temperature_word <= temperature_word_next;
        out_valid        <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data <= result_next;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("result word would be overwritten before it was taken");

  a_phase_legal: assert property (@(posedge clk) disable iff (rst)
    (seq_phase != PH_CONV_P) && (seq_phase <= PH_FAIL))
    else $error("sequencer holds an impossible phase");

  a_result_tracks_phase: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (out_valid && out_data.phase == seq_phase))
    else $error("result phase disagrees with the phase register");

  a_reset_state: assert property (@(posedge clk)
    rst |=> (seq_phase == PH_FAIL && !out_valid))
    else $error("reset did not return the sequencer to fail");

endmodule

`default_nettype wire

### tb/tb_baro_conversion_read_sequencer.sv
`default_nettype none

module tb_baro_conversion_read_sequencer
  import bcrs_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_LO = 2'd2;
  localparam int RANDOM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 156;
  localparam int LONG_HOLD_CYCLES = 60;
  localparam int MAX_PRINTED = 40;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  bcrs_in_t in_data;
  logic out_valid;
  logic out_ready;
  bcrs_out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Shadow copy of the sequencer state and its oversampling registers.
  logic [PHASE_W-1:0] cur_phase;
  logic [OSR_W-1:0] p_osr;
  logic [OSR_W-1:0] t_osr;
  logic [23:0] raw_p;
  logic [23:0] raw_t;

  bcrs_out_t awaited_answers [$];
  int mismatch_count = 0;
  int send_busy = 30;
  bit long_hold_go = 1'b0;
  bit long_hold_done = 1'b0;

  // Directed table.
  bcrs_in_t dir_event [$];
  bit dir_typed [$];
  bcrs_out_t dir_answer [$];

  baro_conversion_read_sequencer u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic [OSR_W-1:0] osr_clip(input logic [OSR_W-1:0] osr);
    return (osr > OSR_MAX) ? OSR_MAX : osr;
  endfunction

  // Applies one event word to the shadow state and returns the answer it should produce.
  function automatic bcrs_out_t advance_sequencer(input bcrs_in_t ev);
    bcrs_out_t r;
    logic [PHASE_W-1:0] ph;
    logic [PHASE_W-1:0] nxt;
    logic [1:0] refuse_status;
    logic [OSR_W-1:0] osr;
    logic [23:0] word;
    r = '0;
    ph = (cur_phase > PH_FAIL) ? PH_FAIL : cur_phase;
    nxt = ph;
    refuse_status = ST_OK;
    word = ev.adc_word & ({24{1'b1}} >> (24 - ADC_WIDTH));
    if (ev.req_type == EV_START) begin
      if (ph == PH_DONE || ph == PH_FAIL) begin
        r.action = ACT_SEND;
        r.cmd_byte = CMD_PRESSURE_BASE + {4'd0, osr_clip(p_osr), 1'b0};
        nxt = PH_WAIT_P;
        refuse_status = ST_LINK;
      end else begin
        r.status = ST_BUSY;
      end
    end else if (ev.req_type == EV_TX && (ph == PH_WAIT_P || ph == PH_WAIT_T)) begin
      r.action = ACT_DELAY;
      osr = osr_clip((ph == PH_WAIT_P) ? p_osr : t_osr);
      case (osr)
        3'd0: r.delay_us = 14'd600;
        3'd1: r.delay_us = 14'd1170;
        3'd2: r.delay_us = 14'd2280;
        3'd3: r.delay_us = 14'd4540;
        default: r.delay_us = 14'd9040;
      endcase
      nxt = ph + 4'd1;
      refuse_status = ST_FAIL;
    end else if (ev.req_type == EV_DELAY && (ph == PH_READ_P || ph == PH_READ_T)) begin
      r.action = ACT_READ;
      r.cmd_byte = CMD_ADC_READ;
      nxt = ph + 4'd1;
      refuse_status = ST_LINK;
    end else if (ev.req_type == EV_XFER && ph == PH_CONV_T) begin
      // The pressure word is kept even if the temperature command is refused.
      raw_p = word;
      r.action = ACT_SEND;
      r.cmd_byte = CMD_TEMPERATURE_BASE + {4'd0, osr_clip(t_osr), 1'b0};
      nxt = PH_WAIT_T;
      refuse_status = ST_LINK;
    end else if (ev.req_type == EV_XFER && ph == PH_FINISH) begin
      raw_t = word;
      ph = PH_DONE;
    end else if (ph == PH_FAIL) begin
      r.status = ST_FAIL;
    end
    if (r.action != ACT_NONE) begin
      if (ev.action_accepted) begin
        ph = nxt;
      end else begin
        ph = PH_FAIL;
        r.status = refuse_status;
      end
    end
    cur_phase = ph;
    r.phase = ph;
    r.data_ready = (ph == PH_DONE);
    r.raw_pressure = raw_p;
    r.raw_temperature = raw_t;
    return r;
  endfunction

  function automatic bcrs_out_t fixed_answer(input logic [1:0] act, input logic [7:0] cmd,
                                             input logic [13:0] dly, input logic [1:0] st,
                                             input logic [PHASE_W-1:0] ph);
    bcrs_out_t r;
    r = '0;
    r.action = act;
    r.cmd_byte = cmd;
    r.delay_us = dly;
    r.status = st;
    r.phase = ph;
    r.data_ready = (ph == PH_DONE);
    return r;
  endfunction

  function automatic int draw_gap(input int busy_pct);
    if ($urandom_range(0, 99) >= busy_pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 30);
    return $urandom_range(1, 3);
  endfunction

  function automatic int pick_busy();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 25;
      default: return 60;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) $display("mismatch at %0t ns: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input int unsigned got, input int unsigned want);
    if (got !== want) report_mismatch($sformatf("%s got %0d, want %0d", name, got, want));
  endtask

  task automatic add_row(input logic [1:0] req, input logic acc, input logic [23:0] adc,
                         input bit typed, input bcrs_out_t answer);
    bcrs_in_t ev;
    ev.req_type = req;
    ev.action_accepted = acc;
    ev.adc_word = adc;
    dir_event.push_back(ev);
    dir_typed.push_back(typed);
    dir_answer.push_back(answer);
  endtask

  // Offers one event word, waits for it to be taken and records the answer it should get.
  // Valid is left high when no gap follows, so the next word goes out back to back.
  task automatic offer_event(input bcrs_in_t ev, input bit typed, input bcrs_out_t answer);
    bcrs_out_t predicted;
    int gap;
    in_data <= ev;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    predicted = advance_sequencer(ev);
    awaited_answers.push_back(typed ? answer : predicted);
    gap = draw_gap(send_busy);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_PRESSURE_OSR) begin
      p_osr = val;
    end else if (idx == REG_TEMPERATURE_OSR) begin
      t_osr = val;
    end
  endtask

  task automatic set_oversampling(input logic [OSR_W-1:0] p, input logic [OSR_W-1:0] t);
    write_reg(REG_PRESSURE_OSR, p);
    write_reg(REG_TEMPERATURE_OSR, t);
    // An index with no register behind it must leave both settings alone.
    write_reg(REG_UNUSED_LO + CFG_INDEX_W'($urandom_range(0, 1)), CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  task automatic drain_answers();
    while (awaited_answers.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  always @(posedge clk) begin : answer_check
    bcrs_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (awaited_answers.size() == 0) begin
        report_mismatch("answer word with nothing outstanding");
      end else begin
        want = awaited_answers.pop_front();
        check_field("action", 32'(out_data.action), 32'(want.action));
        check_field("cmd_byte", 32'(out_data.cmd_byte), 32'(want.cmd_byte));
        check_field("delay_us", 32'(out_data.delay_us), 32'(want.delay_us));
        check_field("status", 32'(out_data.status), 32'(want.status));
        check_field("data_ready", 32'(out_data.data_ready), 32'(want.data_ready));
        check_field("phase", 32'(out_data.phase), 32'(want.phase));
        check_field("raw_pressure", 32'(out_data.raw_pressure), 32'(want.raw_pressure));
        check_field("raw_temperature", 32'(out_data.raw_temperature),
                    32'(want.raw_temperature));
      end
    end
  end

  initial begin : answer_sink
    int stall_left;
    int busy;
    int cyc;
    out_ready = 1'b0;
    stall_left = 0;
    busy = 0;
    cyc = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (long_hold_go && !long_hold_done) begin
        // Hold off long enough for the result register to fill and back up the input.
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold_done = 1'b1;
      end else begin
        if (cyc % 64 == 0) busy = pick_busy();
        cyc++;
        if (stall_left > 0) begin
          out_ready <= 1'b0;
          stall_left--;
        end else begin
          out_ready <= 1'b1;
          stall_left = draw_gap(busy);
        end
      end
    end
  end

  initial begin : watchdog
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    bcrs_in_t ev;
    int cursor;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_PRESSURE_OSR;
    cfg_data = '0;
    cur_phase = PH_FAIL;
    p_osr = '0;
    t_osr = '0;
    raw_p = '0;
    raw_t = '0;
    cursor = 0;

    // Fixed answers hold only for the reset state with both settings at zero.
    add_row(EV_TX, 1'b1, 24'h000000, 1'b1,
            fixed_answer(ACT_NONE, 8'h00, 14'd0, ST_FAIL, PH_FAIL));
    add_row(EV_DELAY, 1'b1, 24'hFFFFFF, 1'b1,
            fixed_answer(ACT_NONE, 8'h00, 14'd0, ST_FAIL, PH_FAIL));
    add_row(EV_XFER, 1'b1, 24'hFFFFFF, 1'b1,
            fixed_answer(ACT_NONE, 8'h00, 14'd0, ST_FAIL, PH_FAIL));
    add_row(EV_START, 1'b0, 24'h000000, 1'b1,
            fixed_answer(ACT_SEND, CMD_PRESSURE_BASE, 14'd0, ST_LINK, PH_FAIL));
    add_row(EV_START, 1'b1, 24'h000000, 1'b1,
            fixed_answer(ACT_SEND, CMD_PRESSURE_BASE, 14'd0, ST_OK, PH_WAIT_P));
    add_row(EV_START, 1'b1, 24'h000000, 1'b1,
            fixed_answer(ACT_NONE, 8'h00, 14'd0, ST_BUSY, PH_WAIT_P));
    add_row(EV_DELAY, 1'b1, 24'h000000, 1'b0, '0);
    add_row(EV_TX, 1'b1, 24'h000000, 1'b1,
            fixed_answer(ACT_DELAY, 8'h00, 14'd600, ST_OK, PH_READ_P));
    add_row(EV_XFER, 1'b1, 24'h123456, 1'b0, '0);
    add_row(EV_DELAY, 1'b1, 24'h000000, 1'b0, '0);
    add_row(EV_XFER, 1'b1, 24'hFFFFFF, 1'b0, '0);
    add_row(EV_TX, 1'b1, 24'h000000, 1'b0, '0);
    add_row(EV_DELAY, 1'b1, 24'h000000, 1'b0, '0);
    add_row(EV_START, 1'b1, 24'h000000, 1'b0, '0);
    // Final transfer ignores a refusal.
    add_row(EV_XFER, 1'b0, 24'h000000, 1'b0, '0);
    add_row(EV_TX, 1'b1, 24'hFFFFFF, 1'b0, '0);
    add_row(EV_START, 1'b1, 24'h000000, 1'b0, '0);
    add_row(EV_TX, 1'b0, 24'h000000, 1'b0, '0);
    add_row(EV_START, 1'b1, 24'h000000, 1'b0, '0);
    add_row(EV_TX, 1'b1, 24'h000000, 1'b0, '0);
    add_row(EV_DELAY, 1'b0, 24'h000000, 1'b0, '0);
    add_row(EV_START, 1'b1, 24'h000000, 1'b0, '0);
    add_row(EV_TX, 1'b1, 24'h000000, 1'b0, '0);
    add_row(EV_DELAY, 1'b1, 24'h000000, 1'b0, '0);
    add_row(EV_XFER, 1'b0, 24'hA5A5A5, 1'b0, '0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    set_oversampling(3'd0, 3'd0);

    for (int i = 0; i < dir_event.size(); i++) begin
      offer_event(dir_event[i], dir_typed[i], dir_answer[i]);
    end
    in_valid <= 1'b0;

    for (int k = 0; k < RANDOM_PHASES; k++) begin
      drain_answers();
      // Both sequences step through every code 0..7 over the phases.
      set_oversampling(OSR_W'((k * 5 + 4) % 8), OSR_W'((k * 3 + 4) % 8));
      if (k == 0) long_hold_go = 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n % 40 == 0) send_busy = pick_busy();
        ev.adc_word = 24'($urandom);
        if ($urandom_range(0, 99) < 15) begin
          ev.req_type = 2'($urandom_range(0, 3));
          ev.action_accepted = 1'($urandom_range(0, 1));
        end else begin
          // Mostly well-formed reads; an occasional refusal breaks the sequence.
          case (cursor)
            0: ev.req_type = EV_START;
            1, 4: ev.req_type = EV_TX;
            2, 5: ev.req_type = EV_DELAY;
            default: ev.req_type = EV_XFER;
          endcase
          ev.action_accepted = ($urandom_range(0, 29) != 0);
          cursor = (cursor == 6) ? 0 : cursor + 1;
        end
        offer_event(ev, 1'b0, '0);
      end
      in_valid <= 1'b0;
    end

    drain_answers();
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
